### hdl/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types and constants of the 4x4 vertex transform block.
// ----------------------------------------------------------------------------
package m4vt_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int MATRIX_DIM = 4;
	localparam int MAT_SIZE   = MATRIX_DIM * MATRIX_DIM;
	localparam int IDX_W      = $clog2(MAT_SIZE);
	localparam int DIM_W      = $clog2(MATRIX_DIM);
	localparam int DATA_W     = 32;
	// Dividend is value * 2^FRAC_BITS, magnitude below 2^(DATA_W+FRAC_BITS).
	localparam int DIVD_W     = DATA_W + FRAC_BITS;
	localparam int QCNT_W     = $clog2(DIVD_W + 1);

	typedef enum logic [1:0] {
		CMD_LOAD_CUR = 2'd0,
		CMD_LOAD_OPD = 2'd1,
		CMD_CONCAT   = 2'd2,
		CMD_XFORM    = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MAC_RD,
		ST_MAC_MUL,
		ST_MAC_ACC,
		ST_CAT_WB,
		ST_CAT_COPY,
		ST_XF_STORE,
		ST_DIV_X,
		ST_DIV_Y,
		ST_DONE
	} state_t;

	// Operand selection for one multiply-accumulate step.
	typedef enum logic [1:0] {
		MSRC_CAT,   // current[i][k] * operand[k][j]
		MSRC_XF     // current[k][j] * p[k]
	} msrc_t;

	typedef struct packed {
		logic              load_cur;
		logic              load_opd;
		logic              capture;   // latch input word
		logic              clr_acc;   // acc <= initial value
		logic              xf_init;   // acc starts from current[3][j]
		logic              rd;        // read operands for (i,j,k)
		logic              mul;       // register product
		logic              acc;       // add product into acc
		msrc_t             msrc;
		logic [DIM_W-1:0]  i;
		logic [DIM_W-1:0]  j;
		logic [DIM_W-1:0]  k;
		logic              cat_wb;    // write acc into result buffer
		logic              copy_wb;   // copy buffer entry into current
		logic [IDX_W-1:0]  copy_idx;
		logic              xf_store;  // store acc into r[j]
		logic              div_start;
		logic              div_sel_y;
		logic              div_step;
		logic              div_fin;   // write quotient to x or y quotient register
		logic              res_load;  // load result register
	} ctl_t;

	typedef struct packed {
		logic       w_zero;
		logic       div_last;
		cmd_t       cmd;
	} sts_t;

endpackage

### hdl/m4vt_datapath.sv
// ----------------------------------------------------------------------------
// m4vt_datapath
// Matrix stores, one shared multiply-accumulate unit and a restoring divider.
// ----------------------------------------------------------------------------
module m4vt_datapath import m4vt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctl_t                     ctl,
	output sts_t                     sts,
	input  logic [1:0]               cmd,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [DATA_W-1:0] elem_value,
	input  logic signed [DATA_W-1:0] px,
	input  logic signed [DATA_W-1:0] py,
	input  logic signed [DATA_W-1:0] pz,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_y,
	output logic signed [DATA_W-1:0] out_z,
	output logic                     div_error
);

	logic        [DATA_W-1:0] cur_q [MAT_SIZE];
	logic        [DATA_W-1:0] opd_q [MAT_SIZE];
	logic        [DATA_W-1:0] buf_q [MAT_SIZE];
	logic                     cur_vld_q [MAT_SIZE];
	cmd_t                     cmd_q;
	logic        [IDX_W-1:0]  idx_q;
	logic        [DATA_W-1:0] val_q;
	logic        [DATA_W-1:0] p_q [3];
	logic signed [DATA_W-1:0] ma_q, mb_q;
	logic signed [2*DATA_W-1:0] prod_q;
	logic        [DATA_W-1:0] acc_q;
	logic        [DATA_W-1:0] r_q [MATRIX_DIM];
	logic        [DATA_W-1:0] qx_q, qy_q;

	logic [DIVD_W-1:0]   rem_q, dvd_q, quo_q;
	logic [DATA_W-1:0]   dvs_q;
	logic                neg_q;
	logic [QCNT_W-1:0]   cnt_q;

	logic [IDX_W-1:0] cat_a, cat_b, xf_a, buf_idx;
	logic [DATA_W-1:0] cur_a, cur_xf, opd_b, init_v;
	logic [DATA_W-1:0] prod_sh;
	logic [DIVD_W:0]   trial;
	logic [DIVD_W-1:0] rem_sh;
	logic [DATA_W-1:0] num_sel, num_abs, den_abs, q_sat;
	logic [DIVD_W:0]   q_signed;

	// Current entries not yet written read as identity.
	function automatic logic [DATA_W-1:0] cur_rd(input logic [IDX_W-1:0] a,
			input logic [DATA_W-1:0] d, input logic v);
		logic [DATA_W-1:0] idv;
		idv = (a[IDX_W-1:DIM_W] == a[DIM_W-1:0]) ?
			DATA_W'(64'd1 << FRAC_BITS) : '0;
		return v ? d : idv;
	endfunction

	assign cat_a   = {ctl.i, ctl.k};
	assign cat_b   = {ctl.k, ctl.j};
	assign xf_a    = {ctl.k, ctl.j};
	assign buf_idx = {ctl.i, ctl.j};
	assign cur_a   = cur_rd(cat_a, cur_q[cat_a], cur_vld_q[cat_a]);
	assign cur_xf  = cur_rd(xf_a, cur_q[xf_a], cur_vld_q[xf_a]);
	assign opd_b   = opd_q[cat_b];
	assign init_v  = cur_rd({DIM_W'(MATRIX_DIM - 1), ctl.j},
		cur_q[{DIM_W'(MATRIX_DIM - 1), ctl.j}],
		cur_vld_q[{DIM_W'(MATRIX_DIM - 1), ctl.j}]);
	assign prod_sh = DATA_W'(prod_q >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < MAT_SIZE; n++) cur_vld_q[n] <= 1'b0;
		end else begin
			if (ctl.load_cur) cur_vld_q[idx_q] <= 1'b1;
			if (ctl.copy_wb) cur_vld_q[ctl.copy_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= cmd_t'(cmd);
			idx_q  <= elem_index;
			val_q  <= elem_value;
			p_q[0] <= px;
			p_q[1] <= py;
			p_q[2] <= pz;
		end
		if (ctl.load_cur) cur_q[idx_q] <= val_q;
		if (ctl.load_opd) opd_q[idx_q] <= val_q;
		if (ctl.copy_wb) cur_q[ctl.copy_idx] <= buf_q[ctl.copy_idx];
		if (ctl.rd) begin
			if (ctl.msrc == MSRC_CAT) begin
				ma_q <= cur_a;
				mb_q <= opd_b;
			end else begin
				ma_q <= cur_xf;
				mb_q <= p_q[ctl.k];
			end
		end
		if (ctl.mul) prod_q <= ma_q * mb_q;
		if (ctl.clr_acc) acc_q <= ctl.xf_init ? init_v : '0;
		else if (ctl.acc) acc_q <= acc_q + prod_sh;
		if (ctl.cat_wb) buf_q[buf_idx] <= acc_q;
		if (ctl.xf_store) r_q[ctl.j] <= acc_q;
	end

	// Restoring division of |num| * 2^FRAC_BITS by |w|, one bit a cycle.
	assign num_sel = ctl.div_sel_y ? r_q[1] : r_q[0];
	assign num_abs = num_sel[DATA_W-1] ? -num_sel : num_sel;
	assign den_abs = r_q[3][DATA_W-1] ? -r_q[3] : r_q[3];
	assign rem_sh  = {rem_q[DIVD_W-2:0], dvd_q[DIVD_W-1]};
	assign trial   = {1'b0, rem_sh} - {{(DIVD_W - DATA_W + 1){1'b0}}, dvs_q};
	assign q_signed = neg_q ? -{1'b0, quo_q} : {1'b0, quo_q};

	always_comb begin
		if (!neg_q && quo_q > DIVD_W'(32'h7fffffff)) q_sat = 32'h7fffffff;
		else if (neg_q && quo_q > DIVD_W'(33'h80000000)) q_sat = 32'h80000000;
		else q_sat = q_signed[DATA_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.div_start) begin
			rem_q <= '0;
			dvd_q <= {num_abs, {FRAC_BITS{1'b0}}};
			dvs_q <= den_abs;
			quo_q <= '0;
			neg_q <= num_sel[DATA_W-1] ^ r_q[3][DATA_W-1];
		end else if (ctl.div_step) begin
			dvd_q <= {dvd_q[DIVD_W-2:0], 1'b0};
			if (!trial[DIVD_W]) begin
				rem_q <= trial[DIVD_W-1:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
		if (ctl.div_fin) begin
			if (ctl.div_sel_y) qy_q <= q_sat;
			else qx_q <= q_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.div_start) begin
			cnt_q <= QCNT_W'(DIVD_W);
		end else if (ctl.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.res_load) begin
			if (cmd_q == CMD_XFORM) begin
				out_z     <= r_q[2];
				div_error <= (r_q[3] == '0);
				out_x     <= (r_q[3] == '0) ? '0 : qx_q;
				out_y     <= (r_q[3] == '0) ? '0 : qy_q;
			end else begin
				out_x     <= '0;
				out_y     <= '0;
				out_z     <= '0;
				div_error <= 1'b0;
			end
		end
	end

	assign sts.w_zero   = (r_q[3] == '0);
	assign sts.div_last = (cnt_q == QCNT_W'(1));
	assign sts.cmd      = cmd_q;

endmodule

### hdl/m4vt_ctrl.sv
// ----------------------------------------------------------------------------
// m4vt_ctrl
// Sequencer: walks the multiply-accumulate loops and the divider steps.
// ----------------------------------------------------------------------------
module m4vt_ctrl import m4vt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output ctl_t ctl
);

	state_t           state_q, state_d;
	logic [DIM_W-1:0] i_q, j_q, k_q, i_d, j_d, k_d;
	logic [IDX_W-1:0] c_q, c_d;
	logic             ysel_q, ysel_d;
	logic             ov_q, ov_d;
	logic             last_k;

	assign last_k = (k_q == DIM_W'(sts.cmd == CMD_XFORM ? 2 : MATRIX_DIM - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q <= '0; j_q <= '0; k_q <= '0; c_q <= '0;
			ysel_q <= 1'b0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q <= i_d; j_q <= j_d; k_q <= k_d; c_q <= c_d;
			ysel_q <= ysel_d;
			ov_q <= ov_d;
		end
	end

	assign out_valid = ov_q;
	// A new word is taken while the previous result still waits.
	assign in_stall  = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		i_d = i_q; j_d = j_q; k_d = k_q; c_d = c_q;
		ysel_d = ysel_q;
		ov_d = ov_q && out_stall;
		ctl = '0;
		ctl.msrc = (sts.cmd == CMD_XFORM) ? MSRC_XF : MSRC_CAT;
		ctl.i = i_q; ctl.j = j_q; ctl.k = k_q;
		ctl.copy_idx = c_q;
		ctl.div_sel_y = ysel_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.capture = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				i_d = '0; j_d = '0; k_d = '0; c_d = '0;
				ysel_d = 1'b0;
				ctl.clr_acc = 1'b1;
				ctl.xf_init = 1'b1;
				case (sts.cmd)
					CMD_LOAD_CUR: begin ctl.load_cur = 1'b1; state_d = ST_DONE; end
					CMD_LOAD_OPD: begin ctl.load_opd = 1'b1; state_d = ST_DONE; end
					CMD_CONCAT: begin ctl.xf_init = 1'b0; state_d = ST_MAC_RD; end
					CMD_XFORM: state_d = ST_MAC_RD;
					default: state_d = ST_DONE;
				endcase
			end
			ST_MAC_RD: begin
				ctl.rd = 1'b1;
				// Each transform column starts from its translation row entry.
				if (sts.cmd == CMD_XFORM && k_q == '0) begin
					ctl.clr_acc = 1'b1;
					ctl.xf_init = 1'b1;
				end
				state_d = ST_MAC_MUL;
			end
			ST_MAC_MUL: begin ctl.mul = 1'b1; state_d = ST_MAC_ACC; end
			ST_MAC_ACC: begin
				ctl.acc = 1'b1;
				if (!last_k) begin
					k_d = k_q + 1'b1;
					state_d = ST_MAC_RD;
				end else if (sts.cmd == CMD_XFORM) begin
					state_d = ST_XF_STORE;
				end else begin
					state_d = ST_CAT_WB;
				end
			end
			ST_CAT_WB: begin
				ctl.cat_wb = 1'b1;
				ctl.clr_acc = 1'b1;
				k_d = '0;
				j_d = j_q + 1'b1;
				state_d = ST_MAC_RD;
				if (j_q == DIM_W'(MATRIX_DIM - 1)) begin
					i_d = i_q + 1'b1;
					if (i_q == DIM_W'(MATRIX_DIM - 1)) state_d = ST_CAT_COPY;
				end
			end
			ST_CAT_COPY: begin
				ctl.copy_wb = 1'b1;
				c_d = c_q + 1'b1;
				if (c_q == IDX_W'(MAT_SIZE - 1)) state_d = ST_DONE;
			end
			ST_XF_STORE: begin
				ctl.xf_store = 1'b1;
				k_d = '0;
				j_d = j_q + 1'b1;
				state_d = (j_q == DIM_W'(MATRIX_DIM - 1)) ? ST_DIV_X : ST_MAC_RD;
			end
			ST_DIV_X: begin
				if (sts.w_zero) begin
					state_d = ST_DONE;
				end else begin
					ctl.div_start = 1'b1;
					state_d = ST_DIV_Y;
				end
			end
			ST_DIV_Y: begin
				ctl.div_step = 1'b1;
				// The quotient is final after this step; it is taken in ST_DONE.
				if (sts.div_last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.cmd == CMD_XFORM && !sts.w_zero && !ysel_q && c_q == '0) begin
					ctl.div_fin = 1'b1;
					ysel_d = 1'b1;
					c_d = IDX_W'(1);
					state_d = ST_DIV_X;
				end else if (sts.cmd == CMD_XFORM && !sts.w_zero && ysel_q
						&& c_q == IDX_W'(1)) begin
					ctl.div_fin = 1'b1;
					c_d = IDX_W'(2);
				end else if (!ov_q || !out_stall) begin
					ctl.res_load = 1'b1;
					ov_d = 1'b1;
					c_d = '0;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

### hdl/matrix4_vertex_transform.sv
// ----------------------------------------------------------------------------
// matrix4_vertex_transform
// 4x4 homogeneous vertex transform with perspective divide, Q16.16.
// ----------------------------------------------------------------------------
// Usage: one input word carries cmd with its element or point fields; each
// word gives exactly one result word on the output channel. Both channels
// use valid/stall. A load passes through the load and done states. A
// transform runs twelve serial multiply-accumulate steps, each a read, a
// multiply and an accumulate state, through one shared 32x32 multiplier
// plus four column stores, then two restoring divisions by w, which are
// skipped when w is zero. A concatenate runs sixty-four such steps,
// sixteen buffer writes and a copy of sixteen entries into the current
// matrix. One word is in work at a time; the next word is taken once the
// result sits in the output register, even while the receiver stalls it.
// If the receiver stalls, the finished result holds and the next result
// waits for it. Reset makes the current matrix identity and clears output
// valid; the operand matrix holds nothing defined until loaded.
// ----------------------------------------------------------------------------
module matrix4_vertex_transform import m4vt_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               cmd,
	input  logic [IDX_W-1:0]         elem_index,
	input  logic signed [DATA_W-1:0] elem_value,
	input  logic signed [DATA_W-1:0] px,
	input  logic signed [DATA_W-1:0] py,
	input  logic signed [DATA_W-1:0] pz,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] out_x,
	output logic signed [DATA_W-1:0] out_y,
	output logic signed [DATA_W-1:0] out_z,
	output logic                     div_error
);

	ctl_t ctl;
	sts_t sts;

	m4vt_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .ctl
	);

	m4vt_datapath u_dp (
		.clk, .arst_n, .ctl, .sts, .cmd, .elem_index, .elem_value,
		.px, .py, .pz, .out_x, .out_y, .out_z, .div_error
	);

endmodule

### hdl/m4vt_checker.sv
// ----------------------------------------------------------------------------
// m4vt_checker
// Port-level checks of the vertex transform block.
// ----------------------------------------------------------------------------
module m4vt_checker import m4vt_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DATA_W-1:0] out_x,
	input logic [DATA_W-1:0] out_y,
	input logic              div_error
);

	// An accepted word always closes the input until its work has run.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not closed after accepted word");

	// A zero divisor never yields nonzero x or y.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_error |-> out_x == '0 && out_y == '0)
		else $error("div_error with nonzero quotient");

	// A result held under stall does not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y))
		else $error("stalled result changed");

endmodule

bind matrix4_vertex_transform m4vt_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
	.out_x, .out_y, .div_error
);

### tb/tb_matrix4_vertex_transform.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_matrix4_vertex_transform
// Self-checking bench for the 4x4 vertex transform with perspective divide.
// Words are queued by a stimulus process, sent by a clocked driver with
// random gaps, and results are compared against a behavioral predictor of
// the matrix state and fixed-point arithmetic.
// ----------------------------------------------------------------------------
module tb_matrix4_vertex_transform import m4vt_pkg::*; ();

	typedef struct packed {
		cmd_t               cmd;
		logic [IDX_W-1:0]   idx;
		logic [DATA_W-1:0]  val;
		logic [DATA_W-1:0]  x;
		logic [DATA_W-1:0]  y;
		logic [DATA_W-1:0]  z;
	} word_t;

	typedef struct packed {
		logic [DATA_W-1:0] x;
		logic [DATA_W-1:0] y;
		logic [DATA_W-1:0] z;
		logic              err;
	} vert_t;

	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] cmd = '0;
	logic [IDX_W-1:0] elem_index = '0;
	logic signed [DATA_W-1:0] elem_value = '0;
	logic signed [DATA_W-1:0] px = '0;
	logic signed [DATA_W-1:0] py = '0;
	logic signed [DATA_W-1:0] pz = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic signed [DATA_W-1:0] out_z;
	logic div_error;

	word_t pending_words[$];
	vert_t expected_verts[$];
	logic signed [31:0] cur_mat[MAT_SIZE];
	logic signed [31:0] opd_mat[MAT_SIZE];
	int errors = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int take_gap = 0;
	bit stim_done = 0;

	matrix4_vertex_transform u_top (.*);

	always #1 clk = ~clk;

	function automatic logic signed [31:0] fx_product(logic signed [31:0] a,
			logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return 32'(p >>> FRAC_BITS);
	endfunction

	function automatic logic signed [31:0] fx_quotient(logic signed [31:0] n,
			logic signed [31:0] d);
		logic signed [63:0] q;
		q = (64'(n) <<< FRAC_BITS) / 64'(d);
		if (q > 64'sd2147483647) return 32'sh7fffffff;
		if (q < -64'sd2147483648) return 32'sh80000000;
		return 32'(q);
	endfunction

	// Applies one word to the matrix state and returns the vertex it yields.
	function automatic vert_t apply_word(word_t w);
		vert_t r;
		logic signed [31:0] prod[MAT_SIZE];
		logic signed [31:0] acc;
		logic signed [31:0] pt[3];
		logic signed [31:0] h[4];
		r = '0;
		case (w.cmd)
			CMD_LOAD_CUR: cur_mat[w.idx] = w.val;
			CMD_LOAD_OPD: opd_mat[w.idx] = w.val;
			CMD_CONCAT: begin
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 4; j++) begin
						acc = 0;
						for (int k = 0; k < 4; k++)
							acc += fx_product(cur_mat[4*i+k], opd_mat[4*k+j]);
						prod[4*i+j] = acc;
					end
				cur_mat = prod;
			end
			default: begin
				pt[0] = w.x;
				pt[1] = w.y;
				pt[2] = w.z;
				for (int j = 0; j < 4; j++) begin
					acc = cur_mat[12+j];
					for (int k = 0; k < 3; k++)
						acc += fx_product(cur_mat[4*k+j], pt[k]);
					h[j] = acc;
				end
				r.z = h[2];
				if (h[3] == 0) begin
					r.err = 1'b1;
				end else begin
					r.x = fx_quotient(h[0], h[3]);
					r.y = fx_quotient(h[1], h[3]);
				end
			end
		endcase
		return r;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h80000000;
			1: return 32'h7fffffff;
			2: return 32'h00010000;
			3: return 32'hffff0000;
			4: return 32'h0;
			5: return $urandom;
			default: return 32'(int'($urandom_range(0, 32'h3ffff)) - 32'h20000);
		endcase
	endfunction

	task automatic queue_word(cmd_t c, int i, logic [31:0] v, logic [31:0] x,
			logic [31:0] y, logic [31:0] z);
		word_t w;
		w.cmd = c;
		w.idx = i[IDX_W-1:0];
		w.val = v;
		w.x = x;
		w.y = y;
		w.z = z;
		pending_words.push_back(w);
	endtask

	// Driver.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_verts.push_back(apply_word(pending_words.pop_front()));
				send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
				in_valid <= 1'b0;
			end else if (!in_valid && pending_words.size() > 0) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else begin
					in_valid <= 1'b1;
					cmd <= pending_words[0].cmd;
					elem_index <= pending_words[0].idx;
					elem_value <= pending_words[0].val;
					px <= pending_words[0].x;
					py <= pending_words[0].y;
					pz <= pending_words[0].z;
				end
			end
		end
	end

	// Monitor and receiver stalls.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_verts.size() == 0) begin
					$display("%0t: unexpected result x=%h y=%h z=%h err=%b", $time,
						out_x, out_y, out_z, div_error);
					errors++;
				end else begin
					vert_t e;
					e = expected_verts.pop_front();
					if (out_x !== e.x) begin
						$display("%0t: out_x expected %h actual %h", $time, e.x, out_x);
						errors++;
					end
					if (out_y !== e.y) begin
						$display("%0t: out_y expected %h actual %h", $time, e.y, out_y);
						errors++;
					end
					if (out_z !== e.z) begin
						$display("%0t: out_z expected %h actual %h", $time, e.z, out_z);
						errors++;
					end
					if (div_error !== e.err) begin
						$display("%0t: div_error expected %b actual %b", $time, e.err,
							div_error);
						errors++;
					end
				end
				take_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
				out_stall <= take_gap > 0;
			end else if (take_gap > 0) begin
				take_gap--;
				out_stall <= take_gap > 0;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int n;
		for (int i = 0; i < MAT_SIZE; i++) begin
			cur_mat[i] = (i % 5 == 0) ? 32'sh10000 : 0;
			opd_mat[i] = 0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		// Directed: identity transform, extremes, zero w, saturation.
		queue_word(CMD_XFORM, 0, 0, 32'h00010000, 32'hfffe0000, 32'h7fffffff);
		queue_word(CMD_XFORM, 15, 32'hffffffff, 32'h80000000, 32'h7fffffff,
			32'h80000000);
		queue_word(CMD_LOAD_CUR, 15, 0, 0, 0, 0);
		queue_word(CMD_XFORM, 0, 0, 32'h00010000, 32'h00020000, 32'h00030000);
		queue_word(CMD_LOAD_CUR, 15, 32'h00000001, 0, 0, 0);
		queue_word(CMD_XFORM, 0, 0, 32'h7fff0000, 32'h80000000, 32'h1);
		queue_word(CMD_LOAD_CUR, 15, 32'hffffffff, 0, 0, 0);
		queue_word(CMD_XFORM, 0, 0, 32'h7fff0000, 32'h80000000, 32'hffffffff);
		for (int i = 0; i < MAT_SIZE; i++)
			queue_word(CMD_LOAD_OPD, i, (i % 5 == 0) ? 32'h00020000 :
				(i == 12 ? 32'h80000000 : 32'h7fffffff), $urandom, $urandom, $urandom);
		queue_word(CMD_CONCAT, 0, 32'hffffffff, 0, 0, 0);
		queue_word(CMD_XFORM, 0, 0, 32'hffffffff, 32'h1, 32'h00008000);
		// Random: mostly loads and transforms, with concatenations.
		n = 0;
		while (n < 1000) begin
			int r;
			r = $urandom_range(0, 9);
			if (r < 4) begin
				queue_word(CMD_LOAD_CUR, $urandom_range(0, 15), pick_value(), $urandom,
					$urandom, $urandom);
			end else if (r < 6) begin
				queue_word(CMD_LOAD_OPD, $urandom_range(0, 15), pick_value(), $urandom,
					$urandom, $urandom);
			end else if (r == 6) begin
				queue_word(CMD_CONCAT, $urandom_range(0, 15), $urandom, $urandom,
					$urandom, $urandom);
			end else begin
				queue_word(CMD_XFORM, $urandom_range(0, 15), $urandom, pick_value(),
					pick_value(), pick_value());
			end
			n++;
		end
		stim_done = 1;
	end

	initial begin
		wait (stim_done && pending_words.size() == 0 && expected_verts.size() == 0
			&& !in_valid);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_verts.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		wait (idle_cycles >= WATCHDOG);
		$display("Some tests failed");
		$finish;
	end

endmodule
